// ----- sv/png_scanline_filter_macros.svh -----
// assertion macros shared by the png scanline filter rtl
// depends on nothing; included by the modules that carry assertions
`ifndef PNG_SCANLINE_FILTER_MACROS_SVH
`define PNG_SCANLINE_FILTER_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define PSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psf assertion failed");

// next-cycle implication, checked at every rising edge outside reset
`define PSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psf assertion failed");

`endif

// ----- sv/psf_pkg.sv -----
// shared constants, types and predictor functions of the png scanline filter
// depends on nothing; imported by the channel interfaces and the top level
package psf_pkg;

  localparam int DEF_MAX_ROW_BYTES = 4096;
  localparam int DEF_MAX_BPP       = 8;

  localparam int BYTE_W     = 8;
  localparam int COL_W      = 13;
  localparam int BPP_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [COL_W-1:0] COL_MAX = '1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP       = 2'd1;

  // direction codes
  localparam logic DIR_FILTER   = 1'b0;
  localparam logic DIR_UNFILTER = 1'b1;

  typedef enum logic [1:0] {
    MODE_SUB   = 2'd0,
    MODE_UP    = 2'd1,
    MODE_AVG   = 2'd2,
    MODE_PAETH = 2'd3
  } mode_t;

  // paeth choice among left (a), above (b) and upper-left (c)
  function automatic logic [BYTE_W-1:0] paeth_pick(
    input logic [BYTE_W-1:0] a,
    input logic [BYTE_W-1:0] b,
    input logic [BYTE_W-1:0] c
  );
    logic signed [BYTE_W+1:0] pa;
    logic signed [BYTE_W+1:0] pb;
    logic signed [BYTE_W+1:0] pc;
    logic [BYTE_W+1:0] da;
    logic [BYTE_W+1:0] db;
    logic [BYTE_W+1:0] dc;
    logic [BYTE_W-1:0] pick;
    pa = $signed({2'b00, b}) - $signed({2'b00, c});
    pb = $signed({2'b00, a}) - $signed({2'b00, c});
    pc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    da = (pa < 0) ? $unsigned(-pa) : $unsigned(pa);
    db = (pb < 0) ? $unsigned(-pb) : $unsigned(pb);
    dc = (pc < 0) ? $unsigned(-pc) : $unsigned(pc);
    if (da <= db && da <= dc) begin
      pick = a;
    end else if (db <= dc) begin
      pick = b;
    end else begin
      pick = c;
    end
    return pick;
  endfunction

  // predictor value for one byte
  function automatic logic [BYTE_W-1:0] predict(
    input mode_t             mode,
    input logic [BYTE_W-1:0] left,
    input logic [BYTE_W-1:0] up,
    input logic [BYTE_W-1:0] upleft
  );
    logic [BYTE_W:0]   sum;
    logic [BYTE_W-1:0] pred;
    sum = {1'b0, left} + {1'b0, up};
    unique case (mode)
      MODE_SUB:   pred = left;
      MODE_UP:    pred = up;
      MODE_AVG:   pred = sum[BYTE_W:1];
      MODE_PAETH: pred = paeth_pick(left, up, upleft);
      default:    pred = left;
    endcase
    return pred;
  endfunction

endpackage

// ----- sv/psf_if.sv -----
// valid/ready channel interfaces for the byte stream and the result stream
// depends on psf_pkg for field widths and the mode type
interface psf_in_if
  import psf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  mode_t             mode;
  logic              top_row;
  logic              end_of_row;

  modport source (output valid, data_byte, mode, top_row, end_of_row, input ready);
  modport sink   (input valid, data_byte, mode, top_row, end_of_row, output ready);
endinterface

interface psf_out_if
  import psf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] result_byte;
  logic              row_last;
  logic              row_overflow;

  modport source (output valid, result_byte, row_last, row_overflow, input ready);
  modport sink   (input valid, result_byte, row_last, row_overflow, output ready);
endinterface

// ----- sv/png_scanline_filter.sv -----
// PNG scanline filter/unfilter for Sub, Up, Average and Paeth, one byte per
// clock in steady state while the output does not stall. The accept cycle
// issues the line memory read of the byte above; the compute stage then
// forms the predictor, the result and the memory write-back and loads the
// output register. The line memory has one read and one write port, and a
// write to the entry being read in the same cycle is forwarded. Left and
// upper-left bytes come from small history registers, so a new byte is taken
// every cycle whatever bytes_per_pixel is, unless the output stalls. The
// line memory needs no clearing if the user lets a byte read an entry only
// after the previous row wrote it, and configuration must be written only
// while the block is empty; the block itself enforces neither.
// depends on psf_pkg, psf_if and png_scanline_filter_macros.svh
`include "png_scanline_filter_macros.svh"

module png_scanline_filter
  import psf_pkg::*;
#(
  parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
  parameter int MAX_BPP       = DEF_MAX_BPP
) (
  input  logic                  clk,
  input  logic                  rst_n,
  psf_in_if.sink                in_chan,
  psf_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int SW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
  localparam logic [BPP_W-1:0] BPP_LIM   = BPP_W'(MAX_BPP);
  localparam logic [SW-1:0]    SLOT_LAST = SW'(MAX_BPP - 1);

  // configuration
  logic             dir_r;
  logic [BPP_W-1:0] bpp_r;
  logic [BPP_W-1:0] bpp_eff;

  // column tracking
  logic [COL_W-1:0] col_r, col_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;

  // accept-side lookups
  logic             in_acc;
  logic             ovf_now;
  logic             has_left_now;
  logic [SW-1:0]    back_now;
  logic [AW-1:0]    rd_addr;
  logic [BPP_W:0]   slot_x, bpp_x, back_x;
  logic             byp_now;

  // compute stage
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_data_r;
  mode_t             s1_mode_r;
  logic              s1_top_r;
  logic              s1_last_r;
  logic              s1_ovf_r;
  logic              s1_has_left_r;
  logic [SW-1:0]     s1_back_r;
  logic [SW-1:0]     s1_slot_r;
  logic [AW-1:0]     s1_addr_r;
  logic              s1_byp_r;
  logic [BYTE_W-1:0] s1_byp_data_r;
  logic [BYTE_W-1:0] mem_q_r;
  logic              s1_fire;
  logic [BYTE_W-1:0] s1_left, s1_up, s1_upleft, s1_pred, s1_result, s1_raw;

  // histories of this row
  logic [BYTE_W-1:0] lrh_r [MAX_BPP];
  logic [BYTE_W-1:0] ulh_r [MAX_BPP];

  // line memory holding the unfiltered previous row
  logic [BYTE_W-1:0] line_mem [MAX_ROW_BYTES];

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_result_r;
  logic              out_last_r;
  logic              out_ovf_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_FILTER;
      bpp_r <= BPP_W'(1);
    end else if (cfg_we) begin
      if (cfg_idx == CFG_DIRECTION) begin
        dir_r <= cfg_wdata[0];
      end else if (cfg_idx == CFG_BPP) begin
        bpp_r <= cfg_wdata[BPP_W-1:0];
      end
    end
  end

  // pixel width clamped to one..MAX_BPP
  always_comb begin
    if (bpp_r == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bpp_r > BPP_LIM) begin
      bpp_eff = BPP_LIM;
    end else begin
      bpp_eff = bpp_r;
    end
  end

  // handshakes
  assign s1_fire       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // accept-side decode: overflow, left availability, history slot
  always_comb begin
    ovf_now      = {{(32 - COL_W){1'b0}}, col_r} >= 32'(MAX_ROW_BYTES);
    has_left_now = col_r >= COL_W'(bpp_eff);
    slot_x       = (BPP_W + 1)'(slot_r);
    bpp_x        = (BPP_W + 1)'(bpp_eff);
    if (slot_x >= bpp_x) begin
      back_x = slot_x - bpp_x;
    end else begin
      back_x = slot_x + (BPP_W + 1)'(MAX_BPP) - bpp_x;
    end
    back_now = back_x[SW-1:0];
    rd_addr  = AW'(col_r);
    byp_now  = s1_fire && !s1_ovf_r && (s1_addr_r == rd_addr);
  end

  // column and slot advance per transfer
  always_comb begin
    col_nxt  = col_r;
    slot_nxt = slot_r;
    if (in_acc) begin
      if (in_chan.end_of_row) begin
        col_nxt  = '0;
        slot_nxt = '0;
      end else if (col_r != COL_MAX) begin
        col_nxt  = col_r + COL_W'(1);
        slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      slot_r <= '0;
    end else begin
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

  // compute stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // compute stage payload, loaded on transfer
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r     <= in_chan.data_byte;
      s1_mode_r     <= in_chan.mode;
      s1_top_r      <= in_chan.top_row;
      s1_last_r     <= in_chan.end_of_row;
      s1_ovf_r      <= ovf_now;
      s1_has_left_r <= has_left_now;
      s1_back_r     <= back_now;
      s1_slot_r     <= slot_r;
      s1_addr_r     <= rd_addr;
      s1_byp_r      <= byp_now;
      s1_byp_data_r <= s1_raw;
    end
  end

  // line memory: write-back from the compute stage, registered read
  always_ff @(posedge clk) begin
    if (s1_fire && !s1_ovf_r) begin
      line_mem[s1_addr_r] <= s1_raw;
    end
    if (in_acc) begin
      mem_q_r <= line_mem[rd_addr];
    end
  end

  // predictor and result
  always_comb begin
    s1_left   = s1_has_left_r ? lrh_r[s1_back_r] : '0;
    s1_upleft = s1_has_left_r ? ulh_r[s1_back_r] : '0;
    if (s1_top_r || s1_ovf_r) begin
      s1_up     = '0;
      s1_upleft = '0;
    end else begin
      s1_up = s1_byp_r ? s1_byp_data_r : mem_q_r;
    end
    s1_pred = predict(s1_mode_r, s1_left, s1_up, s1_upleft);
    if (dir_r == DIR_UNFILTER) begin
      s1_result = s1_data_r + s1_pred;
      s1_raw    = s1_result;
    end else begin
      s1_result = s1_data_r - s1_pred;
      s1_raw    = s1_data_r;
    end
  end

  // left and upper-left histories
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BPP; i++) begin
        lrh_r[i] <= '0;
        ulh_r[i] <= '0;
      end
    end else if (s1_fire) begin
      lrh_r[s1_slot_r] <= s1_raw;
      ulh_r[s1_slot_r] <= s1_up;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_result_r <= s1_result;
      out_last_r   <= s1_last_r;
      out_ovf_r    <= s1_ovf_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_byte  = out_result_r;
  assign out_chan.row_last     = out_last_r;
  assign out_chan.row_overflow = out_ovf_r;

  // checks
  `PSF_ASSERT_NEXT(a_fire_fills_out, clk, rst_n, s1_fire, out_valid_r)
  `PSF_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_r && !s1_fire, s1_valid_r && $stable(s1_addr_r))
  `PSF_ASSERT_NEXT(a_col_step, clk, rst_n, in_acc && !in_chan.end_of_row && col_r != COL_MAX, col_r == $past(col_r) + COL_W'(1))
  `PSF_ASSERT_NOW(a_slot_range, clk, rst_n, 1'b1, slot_r <= SLOT_LAST)

endmodule

// ----- tb/png_scanline_filter_checker.sv -----
// result checker for the png scanline filter: predicts each byte from the input transfers
// and compares it with the result transfers; depends on psf_pkg and the psf_if interfaces
module png_scanline_filter_checker
  import psf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  psf_in_if                     in_mon,
  psf_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] result_byte;
    logic              row_last;
    logic              row_overflow;
  } filt_result_t;

  filt_result_t expected_bytes[$];

  // predictor state: unfiltered previous row, recent raw and above bytes, column
  logic [BYTE_W-1:0] line_mem    [DEF_MAX_ROW_BYTES];
  logic [BYTE_W-1:0] left_hist   [DEF_MAX_BPP];
  logic [BYTE_W-1:0] upleft_hist [DEF_MAX_BPP];
  logic [COL_W-1:0]  col_idx;
  logic              dir_q;
  logic [BPP_W-1:0]  bpp_q;

  initial mismatches = 0;

  function automatic logic [BYTE_W-1:0] paeth_select(
    input logic [BYTE_W-1:0] a,
    input logic [BYTE_W-1:0] b,
    input logic [BYTE_W-1:0] c
  );
    int est;
    int da;
    int db;
    int dc;
    est = int'(a) + int'(b) - int'(c);
    da  = (est > int'(a)) ? est - int'(a) : int'(a) - est;
    db  = (est > int'(b)) ? est - int'(b) : int'(b) - est;
    dc  = (est > int'(c)) ? est - int'(c) : int'(c) - est;
    if (da <= db && da <= dc) begin
      return a;
    end else if (db <= dc) begin
      return b;
    end
    return c;
  endfunction

  // one byte through the filter, updating the row state
  task automatic filter_byte(
    input  logic [BYTE_W-1:0] data,
    input  mode_t             sel,
    input  logic              top,
    input  logic              eor,
    output filt_result_t      res
  );
    int unsigned       col;
    int unsigned       span;
    int unsigned       back;
    logic              ovf;
    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] up;
    logic [BYTE_W-1:0] upleft;
    logic [BYTE_W-1:0] pred;
    logic [BYTE_W-1:0] outb;
    logic [BYTE_W-1:0] raw;
    logic [BYTE_W:0]   sum;
    col    = col_idx;
    span   = (bpp_q == 0) ? 1 : (bpp_q > DEF_MAX_BPP) ? DEF_MAX_BPP : bpp_q;
    ovf    = (col >= DEF_MAX_ROW_BYTES);
    left   = '0;
    up     = '0;
    upleft = '0;
    // left and upper-left read zero before the row start
    if (col >= span) begin
      back   = (col - span) % DEF_MAX_BPP;
      left   = left_hist[back];
      upleft = upleft_hist[back];
    end
    // no row above on a top row or past the line store
    if (top || ovf) begin
      upleft = '0;
    end else begin
      up = line_mem[col];
    end
    sum = {1'b0, left} + {1'b0, up};
    case (sel)
      MODE_SUB:   pred = left;
      MODE_UP:    pred = up;
      MODE_AVG:   pred = sum[BYTE_W:1];
      default:    pred = paeth_select(left, up, upleft);
    endcase
    if (dir_q == DIR_UNFILTER) begin
      outb = data + pred;
      raw  = outb;
    end else begin
      outb = data - pred;
      raw  = data;
    end
    if (!ovf) begin
      line_mem[col] = raw;
    end
    left_hist[col % DEF_MAX_BPP]   = raw;
    upleft_hist[col % DEF_MAX_BPP] = up;
    // column saturates at its maximum until the row ends
    if (eor) begin
      col_idx = '0;
    end else if (col_idx != COL_MAX) begin
      col_idx = col_idx + 1'b1;
    end
    res.result_byte  = outb;
    res.row_last     = eor;
    res.row_overflow = ovf;
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  // compare a result transfer with the oldest expected byte
  task automatic check_result();
    filt_result_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch("result with nothing pending", out_mon.result_byte, 0);
    end else begin
      want = expected_bytes.pop_front();
      if (out_mon.result_byte !== want.result_byte)
        report_mismatch("result_byte", out_mon.result_byte, want.result_byte);
      if (out_mon.row_last !== want.row_last)
        report_mismatch("row_last", out_mon.row_last, want.row_last);
      if (out_mon.row_overflow !== want.row_overflow)
        report_mismatch("row_overflow", out_mon.row_overflow, want.row_overflow);
    end
  endtask

  // sample every transfer and register write at the rising edge
  always @(posedge clk) begin
    filt_result_t res;
    if (!rst_n) begin
      expected_bytes.delete();
      for (int i = 0; i < DEF_MAX_BPP; i++) begin
        left_hist[i]   = '0;
        upleft_hist[i] = '0;
      end
      col_idx = '0;
      dir_q   = DIR_FILTER;
      bpp_q   = BPP_W'(1);
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
      if (in_mon.valid && in_mon.ready) begin
        filter_byte(in_mon.data_byte, in_mon.mode, in_mon.top_row, in_mon.end_of_row, res);
        expected_bytes.push_back(res);
      end
      if (cfg_we) begin
        if (cfg_idx == CFG_DIRECTION) begin
          dir_q = cfg_wdata[0];
        end else if (cfg_idx == CFG_BPP) begin
          bpp_q = cfg_wdata[BPP_W-1:0];
        end
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

// ----- tb/png_scanline_filter_test.sv -----
// top of the png scanline filter testbench: clock, reset, byte stream stimulus,
// register writes and the verdict; depends on psf_pkg, psf_if and the result checker
module png_scanline_filter_test
  import psf_pkg::*;
();

  localparam int unsigned TIMEOUT_CYCLES = 500000;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned DRAIN_CYCLES   = 10;

  // indexes past the two registers, written only to show they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           mismatches;
  int unsigned           pending;

  psf_in_if  in_chan ();
  psf_out_if out_chan ();

  png_scanline_filter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  png_scanline_filter_checker filt_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // stall rates and hold-off requests, written by the stimulus process only; hold_served is counted by the receiver
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_requests;
  int unsigned hold_served;

  // column bookkeeping so that no byte reads a never written line store entry
  int unsigned col_pos;
  int unsigned stored_cols;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #(TIMEOUT_CYCLES * 4);
    $display("Verification failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    hold_served = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served < hold_requests) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // one byte transfer on the input channel
  task automatic send_byte(input logic [BYTE_W-1:0] data, input mode_t sel,
                           input logic top, input logic eor);
    logic top_ok;
    top_ok = top;
    if (!top && col_pos < DEF_MAX_ROW_BYTES && col_pos >= stored_cols) begin
      top_ok = 1'b1;
    end
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_chan.valid      <= 1'b1;
    in_chan.data_byte  <= data;
    in_chan.mode       <= sel;
    in_chan.top_row    <= top_ok;
    in_chan.end_of_row <= eor;
    do @(posedge clk); while (!in_chan.ready);
    if (col_pos < DEF_MAX_ROW_BYTES && col_pos >= stored_cols) begin
      stored_cols = col_pos + 1;
    end
    if (eor) begin
      col_pos = 0;
    end else if (col_pos < COL_MAX) begin
      col_pos++;
    end
  endtask

  // stop offering and wait until every expected byte has come out
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // register writes, legal only while the block is empty
  task automatic write_regs(input logic dir, input logic [BPP_W-1:0] span, input bit spare);
    logic [CFG_DATA_W-2:0] pad;
    pad = (CFG_DATA_W-1)'($urandom);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_DIRECTION;
    cfg_wdata <= {pad, dir};
    @(posedge clk);
    cfg_idx   <= CFG_BPP;
    cfg_wdata <= span;
    @(posedge clk);
    if (spare) begin
      cfg_idx   <= CFG_SPARE_A;
      cfg_wdata <= CFG_DATA_W'($urandom);
      @(posedge clk);
      cfg_idx   <= CFG_SPARE_B;
      cfg_wdata <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(7) == 0) begin
      return $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return BYTE_W'($urandom);
  endfunction

  // rows of random length and content, mostly one filter per row
  task automatic send_rows(input int unsigned n_items);
    int unsigned sent;
    int unsigned row_len;
    logic        row_top;
    logic        top;
    logic        eor;
    mode_t       row_mode;
    mode_t       sel;
    sent = 0;
    while (sent < n_items) begin
      row_len  = ($urandom_range(9) == 0) ? $urandom_range(64, 300) : $urandom_range(1, 40);
      row_top  = ($urandom_range(5) == 0);
      row_mode = mode_t'($urandom_range(3));
      for (int unsigned k = 0; k < row_len && sent < n_items; k++) begin
        top = row_top;
        if ($urandom_range(31) == 0) top = ~top;
        sel = ($urandom_range(3) == 0) ? mode_t'($urandom_range(3)) : row_mode;
        eor = (k == row_len - 1) || ($urandom_range(63) == 0);
        send_byte(pick_byte(), sel, top, eor);
        sent++;
        if (eor) break;
      end
    end
  endtask

  // one setting of the registers and of the idling, then a batch of rows
  task automatic run_phase(input logic dir, input logic [BPP_W-1:0] span,
                           input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned n_items, input bit squeeze);
    drain();
    write_regs(dir, span, 1'($urandom_range(1)));
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (squeeze) hold_requests++;
    send_rows(n_items);
  endtask

  initial begin
    int unsigned style;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_requests      = 0;
    col_pos            = 0;
    stored_cols        = 0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_DIRECTION;
    cfg_wdata          <= '0;
    in_chan.valid      <= 1'b0;
    in_chan.data_byte  <= '0;
    in_chan.mode       <= MODE_SUB;
    in_chan.top_row    <= 1'b0;
    in_chan.end_of_row <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes of the data on a top row and the row below, both directions
    drain();
    write_regs(DIR_FILTER, BPP_W'(1), 1'b1);
    for (int k = 0; k < 8; k++)
      send_byte(k[0] ? 8'hFF : 8'h00, mode_t'(k % 4), 1'b1, k == 7);
    for (int k = 0; k < 8; k++)
      send_byte(k[1] ? 8'hFF : 8'h01, mode_t'(k % 4), 1'b0, k == 7);
    drain();
    write_regs(DIR_UNFILTER, BPP_W'(2), 1'b0);
    for (int k = 0; k < 8; k++)
      send_byte(k[0] ? 8'h00 : 8'hFF, mode_t'(3 - k % 4), 1'b0, k == 7);

    // random rows over several register settings and idling patterns
    run_phase(DIR_FILTER,   BPP_W'(1),  0,  0,  200, 1'b0);
    run_phase(DIR_UNFILTER, BPP_W'(3),  46, 0,  200, 1'b0);
    run_phase(DIR_FILTER,   BPP_W'(8),  0,  46, 200, 1'b0);
    run_phase(DIR_UNFILTER, BPP_W'(0),  8,  8,  150, 1'b0);
    run_phase(DIR_FILTER,   BPP_W'(15), 0,  0,  150, 1'b1);
    for (int p = 0; p < 3; p++) begin
      style = $urandom_range(3);
      case (style)
        0:       run_phase(1'($urandom_range(1)), BPP_W'($urandom_range(15)),
                           0,  0,  150, 1'b0);
        1:       run_phase(1'($urandom_range(1)), BPP_W'($urandom_range(15)),
                           46, 0,  150, 1'b0);
        2:       run_phase(1'($urandom_range(1)), BPP_W'($urandom_range(15)),
                           0,  46, 150, 1'b0);
        default: run_phase(1'($urandom_range(1)), BPP_W'($urandom_range(15)),
                           8,  8,  150, 1'b0);
      endcase
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- png_scanline_filter.f -----
+incdir+sv
sv/psf_pkg.sv
sv/psf_if.sv
sv/png_scanline_filter.sv
tb/png_scanline_filter_checker.sv
tb/png_scanline_filter_test.sv
